### rtl/core/bblur_pkg.sv
// Package for the 3x3 RGB box blur: shared types, register indexes and the
// reciprocal table used by the rounded divide. No dependencies.
package bblur_pkg;

    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 16;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum_red;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_blue;
        logic [CNT_W-1:0] count;
        logic             last;
    } mean_req_t;

    // Scaled reciprocal of twice the pixel count, rounded up. Exact for the
    // numerator range of nine 8-bit pixels.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] r;
        unique case (count)
            4'd2:    r = 16'd16384;
            4'd3:    r = 16'd10923;
            4'd4:    r = 16'd8192;
            4'd6:    r = 16'd5462;
            4'd9:    r = 16'd3641;
            default: r = 16'd32768;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/bblur_mean.sv
// Rounded-mean stage of the box blur: one holding register, a reciprocal
// multiply per channel and the registered output channel. Uses bblur_pkg.
module bblur_mean
    import bblur_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        req_valid,
    input  mean_req_t   req,
    output logic        req_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // blur_red, blur_green, blur_blue
    output logic        m_tlast    // end_of_image
);

    logic                          hold_valid_reg;
    logic                          hold_valid_next;
    mean_req_t                     hold_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [23:0]                   out_data_reg;
    logic                          out_last_reg;
    logic                          move;
    logic [RECIP_W-1:0]            factor;
    logic [SUM_W:0]                num_red;
    logic [SUM_W:0]                num_green;
    logic [SUM_W:0]                num_blue;
    logic [SUM_W+RECIP_W:0]        prod_red;
    logic [SUM_W+RECIP_W:0]        prod_green;
    logic [SUM_W+RECIP_W:0]        prod_blue;

    assign move      = hold_valid_reg && (!out_valid_reg || m_tready);
    assign req_ready = !hold_valid_reg || move;

    assign factor    = recip(hold_reg.count);
    assign num_red   = {hold_reg.sum_red, 1'b0} + (SUM_W+1)'(hold_reg.count);
    assign num_green = {hold_reg.sum_green, 1'b0} + (SUM_W+1)'(hold_reg.count);
    assign num_blue  = {hold_reg.sum_blue, 1'b0} + (SUM_W+1)'(hold_reg.count);
    assign prod_red   = (SUM_W+RECIP_W+1)'(num_red) * (SUM_W+RECIP_W+1)'(factor);
    assign prod_green = (SUM_W+RECIP_W+1)'(num_green) * (SUM_W+RECIP_W+1)'(factor);
    assign prod_blue  = (SUM_W+RECIP_W+1)'(num_blue) * (SUM_W+RECIP_W+1)'(factor);

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (req_valid) begin
            hold_valid_next = 1'b1;
        end else if (move) begin
            hold_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (move) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req_valid) begin
            hold_reg <= req;
        end
        if (move) begin
            out_data_reg <= {prod_blue[RECIP_SHIFT+7:RECIP_SHIFT],
                             prod_green[RECIP_SHIFT+7:RECIP_SHIFT],
                             prod_red[RECIP_SHIFT+7:RECIP_SHIFT]};
            out_last_reg <= hold_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

### rtl/core/box_blur_3x3_rgb.sv
// Top level of the streaming 3x3 RGB box blur: two line stores, the sliding
// window and the position counters. Depends on bblur_pkg and bblur_mean.
//
// Pixels arrive in raster order and each result word is the rounded mean of
// the in-image 3x3 neighborhood, lagging the input by image_width+1 words;
// after the last pixel, image_width+1 drain words (tuser high) flush the rest,
// and the final result carries tlast. Each input word is taken in ST_IDLE,
// which starts the registered read of the line stores; ST_READ then updates
// window, stores and counters and takes no new word. A drain word that comes
// while pixels are still expected is ignored. A new word is taken while a
// finished result waits on the output, if bblur_mean is ready. The line stores
// need no clearing pass after reset. A configuration write starts a new image.
module box_blur_3x3_rgb
    import bblur_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [10:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pixel_red, pixel_green, pixel_blue
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // blur_red, blur_green, blur_blue
    output logic        m_tlast    // end_of_image
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    logic [23:0] upper_mem [MAX_WIDTH];
    logic [23:0] middle_mem [MAX_WIDTH];

    state_t          state_reg;
    state_t          state_next;
    logic [WW-1:0]   width_reg;
    logic [HW-1:0]   height_reg;
    logic [WW-1:0]   width_clamped;
    logic [HW-1:0]   height_clamped;
    logic [CW-1:0]   in_col_reg;
    logic [RW-1:0]   in_row_reg;
    logic [CW-1:0]   out_col_reg;
    logic [RW-1:0]   out_row_reg;
    logic [23:0]     pix_reg;
    logic            drain_reg;
    logic [23:0]     upper_q_reg;
    logic [23:0]     middle_q_reg;
    logic [23:0]     win_left_reg [3];
    logic [23:0]     win_centre_reg [3];

    logic            in_fire;
    logic            row_beyond;
    logic            early_drain;
    logic            go_read;
    logic            in_read;
    logic            started;
    logic            emit_pre;
    logic            last;
    logic            skip_update;
    logic            do_update;
    logic [23:0]     bottom_pix;
    logic [23:0]     grid [3][3];
    logic            row_use [3];
    logic            col_use [3];
    logic [1:0]      rows_n;
    logic [1:0]      cols_n;
    logic [RW-1:0]   height_ext;
    logic            in_col_wrap;
    logic            out_col_wrap;
    mean_req_t       mean_req;
    logic            mean_req_valid;
    logic            mean_req_ready;

    always_comb begin
        if (cfg_wdata == 11'd0) begin
            width_clamped  = WW'(1);
            height_clamped = HW'(1);
        end else begin
            width_clamped  = ({21'd0, cfg_wdata} > 32'(MAX_WIDTH))
                             ? WW'(MAX_WIDTH) : WW'(cfg_wdata);
            height_clamped = ({21'd0, cfg_wdata} > 32'(MAX_HEIGHT))
                             ? HW'(MAX_HEIGHT) : HW'(cfg_wdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WW'(MAX_WIDTH);
            height_reg <= HW'(MAX_HEIGHT);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= width_clamped;
                REG_IMAGE_HEIGHT: height_reg <= height_clamped;
            endcase
        end
    end

    assign height_ext  = RW'(height_reg);
    assign in_fire     = s_tvalid && s_tready;
    assign row_beyond  = in_row_reg >= height_ext;
    assign early_drain = s_tuser && !row_beyond;
    assign go_read     = in_fire && !early_drain;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (go_read) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        in_read  = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = mean_req_ready;
            ST_READ: in_read  = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (go_read) begin
            pix_reg   <= s_tdata;
            drain_reg <= s_tuser || row_beyond;
        end
    end

    always_ff @(posedge aclk) begin
        if (go_read) begin
            upper_q_reg <= upper_mem[in_col_reg];
        end
        if (do_update) begin
            upper_mem[in_col_reg] <= middle_q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (go_read) begin
            middle_q_reg <= middle_mem[in_col_reg];
        end
        if (do_update) begin
            middle_mem[in_col_reg] <= bottom_pix;
        end
    end

    assign started     = (in_row_reg >= RW'(2))
                         || (in_row_reg == RW'(1) && in_col_reg != '0);
    assign emit_pre    = (in_col_reg == '0) && started;
    assign last        = (out_row_reg == height_ext - RW'(1))
                         && (out_col_reg == CW'(width_reg - WW'(1)));
    assign skip_update = emit_pre && last;
    assign do_update   = in_read && !skip_update;
    assign bottom_pix  = drain_reg ? 24'd0 : pix_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            grid[i][0] = win_left_reg[i];
            grid[i][1] = win_centre_reg[i];
        end
        grid[0][2] = upper_q_reg;
        grid[1][2] = middle_q_reg;
        grid[2][2] = bottom_pix;
        row_use[0] = out_row_reg != '0;
        row_use[1] = 1'b1;
        row_use[2] = (out_row_reg + RW'(1)) < height_ext;
        col_use[0] = out_col_reg != '0;
        col_use[1] = 1'b1;
        col_use[2] = !emit_pre && ((WW'(out_col_reg) + WW'(1)) < width_reg);
        rows_n = 2'd1 + 2'(row_use[0]) + 2'(row_use[2]);
        cols_n = 2'd1 + 2'(col_use[0]) + 2'(col_use[2]);
    end

    always_comb begin
        mean_req.sum_red   = '0;
        mean_req.sum_green = '0;
        mean_req.sum_blue  = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (row_use[i] && col_use[j]) begin
                    mean_req.sum_red   = mean_req.sum_red + SUM_W'(grid[i][j][7:0]);
                    mean_req.sum_green = mean_req.sum_green + SUM_W'(grid[i][j][15:8]);
                    mean_req.sum_blue  = mean_req.sum_blue + SUM_W'(grid[i][j][23:16]);
                end
            end
        end
        mean_req.count = CNT_W'(rows_n) * CNT_W'(cols_n);
        mean_req.last  = last;
    end

    assign mean_req_valid = in_read && started;

    always_ff @(posedge aclk) begin
        if (do_update) begin
            for (int i = 0; i < 3; i++) begin
                win_left_reg[i] <= win_centre_reg[i];
            end
            win_centre_reg[0] <= upper_q_reg;
            win_centre_reg[1] <= middle_q_reg;
            win_centre_reg[2] <= bottom_pix;
        end
    end

    assign in_col_wrap  = (WW'(in_col_reg) + WW'(1)) == width_reg;
    assign out_col_wrap = (WW'(out_col_reg) + WW'(1)) == width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (in_read) begin
            if (started && last) begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end else begin
                if (in_col_wrap) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + RW'(1);
                end else begin
                    in_col_reg <= in_col_reg + CW'(1);
                end
                if (started) begin
                    if (out_col_wrap) begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + RW'(1);
                    end else begin
                        out_col_reg <= out_col_reg + CW'(1);
                    end
                end
            end
        end
    end

    bblur_mean u_mean (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (mean_req_valid),
        .req       (mean_req),
        .req_ready (mean_req_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
